### hdl/go_to_point_drive_control_macros.svh
// assertion macros for the go-to-point drive controller
`ifndef GO_TO_POINT_DRIVE_CONTROL_MACROS_SVH
`define GO_TO_POINT_DRIVE_CONTROL_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define GTP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// next-cycle implication
`define GTP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define GTP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GTP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/gtp_pkg.sv
// shared types and constants of the go-to-point drive controller
`timescale 1ns / 1ps
package gtp_pkg;

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int ANG_W       = 26;
  localparam int ATAN_W      = 22;
  localparam int ATAN_LEN    = 24;
  localparam int HEAD_W      = 16;
  localparam int E_W         = 17;
  localparam int SPEED_W     = 14;
  localparam int ROT_W       = 34;
  localparam int QUEUE_DEPTH = 4;

  localparam logic signed [ANG_W-1:0] HALF_TURN_Z    = 26'sd11796480;
  localparam logic signed [E_W-1:0]   HALF_TURN_64   = 17'sd11520;
  localparam logic signed [E_W-1:0]   FULL_TURN_64   = 17'sd23040;
  localparam logic signed [E_W-1:0]   QUARTER_TURN_64 = 17'sd5760;
  localparam logic [15:0]             INV_GAIN_Q16   = 16'd39797;
  localparam logic [31:0]             INV_GAIN_Q30   = 32'd652032874;
  localparam logic signed [15:0]      SPIN_POWER     = 16'sd48;

  // arctangent of 2^-i in 2^-16 degree
  localparam logic [ATAN_W-1:0] ATAN_TAB [ATAN_LEN] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
    22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
    22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
  };

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TARGET_X      = 3'd0,
    REG_TARGET_Y      = 3'd1,
    REG_MAX_SPEED     = 3'd2,
    REG_STOP_RADIUS   = 3'd3,
    REG_DISTANCE_GAIN = 3'd4,
    REG_STEER_GAIN    = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_DRIVE   = 2'd0,
    MODE_RANGE   = 2'd1,
    MODE_LOST    = 2'd2,
    MODE_ARRIVED = 2'd3
  } drive_mode_e;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] target_x;
    logic [CFG_DATA_W-1:0] target_y;
    logic [9:0]            max_speed;
    logic [14:0]           stop_radius;
    logic [11:0]           distance_gain;
    logic [11:0]           steer_gain;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // zero-extended angle step for one cordic iteration
  function automatic logic signed [ANG_W-1:0] atan_step(logic [4:0] idx);
    return {{(ANG_W-ATAN_W){1'b0}}, ATAN_TAB[idx]};
  endfunction

endpackage

### hdl/gtp_if.sv
// valid/ready channel interfaces for pose, drive result and configuration
`timescale 1ns / 1ps
interface gtp_pose_if;
  logic        valid;
  logic        ready;
  logic [15:0] x_pos;
  logic [15:0] y_pos;
  logic [15:0] yaw;
  logic        range_valid;
  logic        tracking_ok;
  modport source (output valid, x_pos, y_pos, yaw, range_valid, tracking_ok,
                  input ready);
  modport sink (input valid, x_pos, y_pos, yaw, range_valid, tracking_ok,
                output ready);
endinterface

interface gtp_drive_if;
  logic        valid;
  logic        ready;
  logic [15:0] left_power;
  logic [15:0] right_power;
  logic [1:0]  drive_mode;
  logic        arrived;
  modport source (output valid, left_power, right_power, drive_mode, arrived,
                  input ready);
  modport sink (input valid, left_power, right_power, drive_mode, arrived,
                output ready);
endinterface

interface gtp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gtp_pkg::CFG_ADDR_W-1:0]  index;
  logic [gtp_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/go_to_point_drive_control.sv
// top level of the go-to-point drive controller
//
// pose_i carries one pose item (x, y, yaw, range and tracking flags) per
// valid/ready handshake; drive_o returns one result item per pose item, in
// order, with left/right wheel power, drive mode and arrival flag. cfg_i
// writes target, speed limit, stop radius and gains by register index; it
// is always ready and should be used only while no item is in flight.
// Throughput is one item per clock while the queue is not full. Items
// pass through two pipelined cordic units (vectoring in the front,
// rotation in the back). The front and back pipelines are joined by a
// four-entry queue: when the receiver holds drive_o.ready low, the back
// pipeline and its output register freeze, the queue fills, and
// pose_i.ready drops only once the queue is full. Reset clears all valid
// bits and the queue and loads the register defaults; the block accepts
// items in the first cycle after it.
`timescale 1ns / 1ps
`include "go_to_point_drive_control_macros.svh"
module go_to_point_drive_control #(
  parameter int COORD_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gtp_pose_if.sink    pose_i,
  gtp_cfg_if.sink     cfg_i,
  gtp_drive_if.source drive_o
);

  localparam int DW = COORD_WIDTH + 5;
  localparam int HW = gtp_pkg::HEAD_W;
  localparam int QW = DW + HW + 16 + 2;

  gtp_pkg::cfg_t        cfg_q;
  logic                 front_en, back_en, push, pop;
  logic                 f_valid, b_valid;
  logic [DW-1:0]        f_dist, q_dist;
  logic [HW-1:0]        f_head, q_head;
  logic [15:0]          f_yaw, q_yaw;
  gtp_pkg::drive_mode_e f_mode, q_mode, b_mode;
  logic [QW-1:0]        q_in, q_out;
  gtp_pkg::q_status_t   q_status;
  logic [15:0]          b_left, b_right;
  logic                 b_arrived;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_x      <= '0;
      cfg_q.target_y      <= '0;
      cfg_q.max_speed     <= '0;
      cfg_q.stop_radius   <= 15'd32;
      cfg_q.distance_gain <= 12'd640;
      cfg_q.steer_gain    <= 12'd141;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        gtp_pkg::REG_TARGET_X:      cfg_q.target_x      <= cfg_i.data;
        gtp_pkg::REG_TARGET_Y:      cfg_q.target_y      <= cfg_i.data;
        gtp_pkg::REG_MAX_SPEED:     cfg_q.max_speed     <= cfg_i.data[9:0];
        gtp_pkg::REG_STOP_RADIUS:   cfg_q.stop_radius   <= cfg_i.data[14:0];
        gtp_pkg::REG_DISTANCE_GAIN: cfg_q.distance_gain <= cfg_i.data[11:0];
        gtp_pkg::REG_STEER_GAIN:    cfg_q.steer_gain    <= cfg_i.data[11:0];
        default: ;
      endcase
    end
  end
  assign cfg_i.ready = 1'b1;

  // flow control: front stalls on a full queue, back on a held result
  assign front_en     = !q_status.full;
  assign pose_i.ready = front_en;
  assign push         = f_valid && front_en;
  assign back_en      = !b_valid || drive_o.ready;
  assign pop          = back_en && !q_status.empty;

  gtp_front #(
    .COORD_WIDTH   (COORD_WIDTH),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (front_en),
    .in_valid_i    (pose_i.valid),
    .x_pos_i       (pose_i.x_pos),
    .y_pos_i       (pose_i.y_pos),
    .yaw_i         (pose_i.yaw),
    .range_valid_i (pose_i.range_valid),
    .tracking_ok_i (pose_i.tracking_ok),
    .cfg_i         (cfg_q),
    .out_valid_o   (f_valid),
    .out_dist_o    (f_dist),
    .out_head_o    (f_head),
    .out_yaw_o     (f_yaw),
    .out_mode_o    (f_mode)
  );

  assign q_in = {f_dist, f_head, f_yaw, f_mode};

  gtp_queue #(
    .WIDTH (QW),
    .DEPTH (gtp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (q_in),
    .pop_i    (pop),
    .data_o   (q_out),
    .status_o (q_status)
  );

  assign q_dist = q_out[QW-1 -: DW];
  assign q_head = q_out[HW+17:18];
  assign q_yaw  = q_out[17:2];
  assign q_mode = gtp_pkg::drive_mode_e'(q_out[1:0]);

  gtp_back #(
    .COORD_WIDTH   (COORD_WIDTH),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (back_en),
    .in_valid_i    (pop),
    .in_dist_i     (q_dist),
    .in_head_i     (q_head),
    .in_yaw_i      (q_yaw),
    .in_mode_i     (q_mode),
    .cfg_i         (cfg_q),
    .out_valid_o   (b_valid),
    .left_power_o  (b_left),
    .right_power_o (b_right),
    .mode_o        (b_mode),
    .arrived_o     (b_arrived)
  );

  assign drive_o.valid       = b_valid;
  assign drive_o.left_power  = b_left;
  assign drive_o.right_power = b_right;
  assign drive_o.drive_mode  = b_mode;
  assign drive_o.arrived     = b_arrived;

  // result consistency checks
  `GTP_ASSERT_IMP(a_arrived_flag, clk_i, rst_ni, b_valid, b_arrived == (b_mode == gtp_pkg::MODE_ARRIVED))
  `GTP_ASSERT_IMP(a_spin_power, clk_i, rst_ni, b_valid && (b_mode == gtp_pkg::MODE_LOST), (b_left == 16'hffd0) && (b_right == 16'h0030))
  `GTP_ASSERT_IMP(a_stop_power, clk_i, rst_ni, b_valid && ((b_mode == gtp_pkg::MODE_RANGE) || (b_mode == gtp_pkg::MODE_ARRIVED)), (b_left == 16'h0) && (b_right == 16'h0))
  `GTP_ASSERT_NXT(a_full_no_push, clk_i, rst_ni, q_status.full && !pop, q_status.full)

endmodule

### hdl/gtp_front.sv
// front pipeline: vectoring cordic, distance scaling and item classification
`timescale 1ns / 1ps
module gtp_front #(
  parameter int COORD_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               in_valid_i,
  input  logic [15:0]                        x_pos_i,
  input  logic [15:0]                        y_pos_i,
  input  logic [15:0]                        yaw_i,
  input  logic                               range_valid_i,
  input  logic                               tracking_ok_i,
  input  gtp_pkg::cfg_t                      cfg_i,
  output logic                               out_valid_o,
  output logic [COORD_WIDTH+4:0]             out_dist_o,
  output logic [gtp_pkg::HEAD_W-1:0]         out_head_o,
  output logic [15:0]                        out_yaw_o,
  output gtp_pkg::drive_mode_e               out_mode_o
);

  localparam int CW = COORD_WIDTH;
  localparam int XW = COORD_WIDTH + 18;
  localparam int DW = COORD_WIDTH + 5;
  localparam int AW = gtp_pkg::ANG_W;
  localparam int NS = CORDIC_STAGES;

  logic [CW-1:0]        xp, yp, tx, ty;
  logic signed [CW:0]   dx, dy;
  logic signed [XW-1:0] dxw, dyw, x_in, y_in;
  logic signed [AW-1:0] z_in;

  logic signed [XW-1:0] x_q [NS+1];
  logic signed [XW-1:0] y_q [NS+1];
  logic signed [AW-1:0] z_q [NS+1];
  logic [15:0]          yaw_q [NS+1];
  logic [NS:0]          rv_q, tk_q;
  logic [NS+2:0]        v_q;

  logic [XW-1:0]        hi_q;
  logic [15:0]          lo_q;
  logic [31:0]          lo_mul;
  logic signed [AW-1:0] z_rnd;
  logic [AW-11:0]       head1_q;
  logic [15:0]          yaw1_q;
  logic                 rv1_q, tk1_q;
  logic [XW:0]          dsum;
  logic [DW-1:0]        dist_w;
  gtp_pkg::drive_mode_e mode;

  logic [DW-1:0]        dist2_q;
  logic [AW-11:0]       head2_q;
  logic [15:0]          yaw2_q;
  gtp_pkg::drive_mode_e mode2_q;

  // position fields taken at coordinate width
  if (CW > 16) begin : g_wide
    assign xp = {{(CW-16){1'b0}}, x_pos_i};
    assign yp = {{(CW-16){1'b0}}, y_pos_i};
  end else begin : g_narrow
    assign xp = x_pos_i[CW-1:0];
    assign yp = y_pos_i[CW-1:0];
  end
  assign tx = cfg_i.target_x[CW-1:0];
  assign ty = cfg_i.target_y[CW-1:0];

  // difference vector, scaled and folded into the right half plane
  always_comb begin
    dx   = $signed({tx[CW-1], tx}) - $signed({xp[CW-1], xp});
    dy   = $signed({ty[CW-1], ty}) - $signed({yp[CW-1], yp});
    dxw  = XW'(dx) <<< 14;
    dyw  = XW'(dy) <<< 14;
    x_in = dxw;
    y_in = dyw;
    z_in = '0;
    if (dx[CW]) begin
      x_in = -dxw;
      y_in = -dyw;
      z_in = dy[CW] ? -gtp_pkg::HALF_TURN_Z : gtp_pkg::HALF_TURN_Z;
    end
  end

  // vectoring cordic stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= x_in;
      y_q[0]   <= y_in;
      z_q[0]   <= z_in;
      yaw_q[0] <= yaw_i;
      rv_q[0]  <= range_valid_i;
      tk_q[0]  <= tracking_ok_i;
      for (int i = 0; i < NS; i++) begin
        if (!y_q[i][XW-1]) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + gtp_pkg::atan_step(5'(i));
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - gtp_pkg::atan_step(5'(i));
        end
        yaw_q[i+1] <= yaw_q[i];
        rv_q[i+1]  <= rv_q[i];
        tk_q[i+1]  <= tk_q[i];
      end
    end
  end

  // gain correction products and rounded heading
  assign lo_mul = {16'b0, x_q[NS][15:0]} * {16'b0, gtp_pkg::INV_GAIN_Q16};
  assign z_rnd  = z_q[NS] + AW'(512);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hi_q    <= XW'(x_q[NS][XW-1:16]) * XW'(gtp_pkg::INV_GAIN_Q16);
      lo_q    <= lo_mul[31:16];
      head1_q <= z_rnd[AW-1:10];
      yaw1_q  <= yaw_q[NS];
      rv1_q   <= rv_q[NS];
      tk1_q   <= tk_q[NS];
    end
  end

  // distance and classification
  always_comb begin
    dsum   = {1'b0, hi_q} + (XW+1)'(lo_q) + (XW+1)'(8192);
    dist_w = dsum[XW:14];
    if (dist_w <= DW'(cfg_i.stop_radius)) begin
      mode = gtp_pkg::MODE_ARRIVED;
    end else if (!rv1_q) begin
      mode = gtp_pkg::MODE_RANGE;
    end else if (!tk1_q) begin
      mode = gtp_pkg::MODE_LOST;
    end else begin
      mode = gtp_pkg::MODE_DRIVE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dist2_q <= dist_w;
      head2_q <= head1_q;
      yaw2_q  <= yaw1_q;
      mode2_q <= mode;
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS+1:0], in_valid_i};
    end
  end

  assign out_valid_o = v_q[NS+2];
  assign out_dist_o  = dist2_q;
  assign out_head_o  = head2_q;
  assign out_yaw_o   = yaw2_q;
  assign out_mode_o  = mode2_q;

endmodule

### hdl/gtp_queue.sv
// short item queue between the front and back pipelines
`timescale 1ns / 1ps
module gtp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [WIDTH-1:0]   data_i,
  input  logic               pop_i,
  output logic [WIDTH-1:0]   data_o,
  output gtp_pkg::q_status_t status_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign data_o         = mem_q[rd_q];
  assign status_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign status_o.empty = (cnt_q == '0);

endmodule

### hdl/gtp_back.sv
// back pipeline: speed, heading error, rotation cordic and wheel powers
`timescale 1ns / 1ps
module gtp_back #(
  parameter int COORD_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       in_valid_i,
  input  logic [COORD_WIDTH+4:0]     in_dist_i,
  input  logic [gtp_pkg::HEAD_W-1:0] in_head_i,
  input  logic [15:0]                in_yaw_i,
  input  gtp_pkg::drive_mode_e       in_mode_i,
  input  gtp_pkg::cfg_t              cfg_i,
  output logic                       out_valid_o,
  output logic [15:0]                left_power_o,
  output logic [15:0]                right_power_o,
  output gtp_pkg::drive_mode_e       mode_o,
  output logic                       arrived_o
);

  localparam int DW  = COORD_WIDTH + 5;
  localparam int AW  = gtp_pkg::ANG_W;
  localparam int EW  = gtp_pkg::E_W;
  localparam int SW  = gtp_pkg::SPEED_W;
  localparam int RW  = gtp_pkg::ROT_W;
  localparam int KW  = RW + 5;
  localparam int PW  = KW + 16;
  localparam int OW  = PW - 30;
  localparam int NS  = CORDIC_STAGES;
  localparam logic signed [PW-1:0] RND    = PW'(536870912);
  localparam logic signed [OW-1:0] SAT_HI = OW'(32767);
  localparam logic signed [OW-1:0] SAT_LO = OW'(-32768);

  // entry stage
  logic signed [EW-1:0] diff, w1, w2, e_fold;
  logic                 flip;
  logic [DW+11:0]       prod_q;
  logic signed [EW-1:0] e_q;
  logic                 flip0_q;
  gtp_pkg::drive_mode_e mode0_q;

  // speed and rotation stages
  logic [DW+12:0]       rnd_sum;
  logic [SW-1:0]        lim, speed;
  logic signed [RW-1:0] c_q [NS+1];
  logic signed [RW-1:0] s_q [NS+1];
  logic signed [AW-1:0] z_q [NS+1];
  logic [SW-1:0]        sp_q [NS+1];
  logic [NS:0]          fl_q;
  gtp_pkg::drive_mode_e md_q [NS+1];

  // steering stages
  logic signed [RW-1:0] cf, sf;
  logic signed [RW+12:0] kp;
  logic signed [RW-1:0] c2_q;
  logic signed [KW-1:0] ks_q;
  logic [SW-1:0]        sp2_q;
  gtp_pkg::drive_mode_e md2_q;
  logic signed [KW:0]   dl, dr;
  logic signed [PW-1:0] pl_q, pr_q;
  gtp_pkg::drive_mode_e md3_q;

  // output register
  logic signed [PW-1:0] rl_sum, rr_sum;
  logic signed [OW-1:0] rl, rr;
  logic [15:0]          lsat, rsat, lp_d, rp_d, lp_q, rp_q;
  gtp_pkg::drive_mode_e md4_q;
  logic [NS+4:0]        v_q;

  // heading error wrapped to a half turn each way, then folded
  always_comb begin
    diff = $signed({in_head_i[gtp_pkg::HEAD_W-1], in_head_i})
         - $signed({in_yaw_i[15], in_yaw_i});
    w1 = diff;
    if (diff >= gtp_pkg::HALF_TURN_64) begin
      w1 = diff - gtp_pkg::FULL_TURN_64;
    end else if (diff < -gtp_pkg::HALF_TURN_64) begin
      w1 = diff + gtp_pkg::FULL_TURN_64;
    end
    w2 = w1;
    if (w1 >= gtp_pkg::HALF_TURN_64) begin
      w2 = w1 - gtp_pkg::FULL_TURN_64;
    end else if (w1 < -gtp_pkg::HALF_TURN_64) begin
      w2 = w1 + gtp_pkg::FULL_TURN_64;
    end
    e_fold = w2;
    flip   = 1'b0;
    if (w2 > gtp_pkg::QUARTER_TURN_64) begin
      e_fold = w2 - gtp_pkg::HALF_TURN_64;
      flip   = 1'b1;
    end else if (w2 < -gtp_pkg::QUARTER_TURN_64) begin
      e_fold = w2 + gtp_pkg::HALF_TURN_64;
      flip   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= (DW+12)'(in_dist_i) * (DW+12)'(cfg_i.distance_gain);
      e_q     <= e_fold;
      flip0_q <= flip;
      mode0_q <= in_mode_i;
    end
  end

  // rounded speed clipped to the limit
  always_comb begin
    rnd_sum = {1'b0, prod_q} + (DW+13)'(128);
    lim     = {cfg_i.max_speed, 4'b0};
    speed   = (rnd_sum[DW+12:8] > (DW+5)'(lim)) ? lim : rnd_sum[SW+7:8];
  end

  // rotation cordic stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q[0]  <= RW'(gtp_pkg::INV_GAIN_Q30);
      s_q[0]  <= '0;
      z_q[0]  <= AW'(e_q) <<< 10;
      sp_q[0] <= speed;
      fl_q[0] <= flip0_q;
      md_q[0] <= mode0_q;
      for (int i = 0; i < NS; i++) begin
        if (!z_q[i][AW-1]) begin
          c_q[i+1] <= c_q[i] - (s_q[i] >>> i);
          s_q[i+1] <= s_q[i] + (c_q[i] >>> i);
          z_q[i+1] <= z_q[i] - gtp_pkg::atan_step(5'(i));
        end else begin
          c_q[i+1] <= c_q[i] + (s_q[i] >>> i);
          s_q[i+1] <= s_q[i] - (c_q[i] >>> i);
          z_q[i+1] <= z_q[i] + gtp_pkg::atan_step(5'(i));
        end
        sp_q[i+1] <= sp_q[i];
        fl_q[i+1] <= fl_q[i];
        md_q[i+1] <= md_q[i];
      end
    end
  end

  // unfold and weight the sine by the steering gain
  always_comb begin
    cf = fl_q[NS] ? -c_q[NS] : c_q[NS];
    sf = fl_q[NS] ? -s_q[NS] : s_q[NS];
    kp = sf * $signed({1'b0, cfg_i.steer_gain});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c2_q  <= cf;
      ks_q  <= kp[RW+12:8];
      sp2_q <= sp_q[NS];
      md2_q <= md_q[NS];
    end
  end

  // wheel products
  assign dl = (KW+1)'(c2_q) - (KW+1)'(ks_q);
  assign dr = (KW+1)'(c2_q) + (KW+1)'(ks_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q  <= dl * $signed({1'b0, sp2_q});
      pr_q  <= dr * $signed({1'b0, sp2_q});
      md3_q <= md2_q;
    end
  end

  // round, saturate and select by mode
  always_comb begin
    rl_sum = pl_q + RND;
    rr_sum = pr_q + RND;
    rl     = rl_sum[PW-1:30];
    rr     = rr_sum[PW-1:30];
    if (rl > SAT_HI) begin
      lsat = 16'h7fff;
    end else if (rl < SAT_LO) begin
      lsat = 16'h8000;
    end else begin
      lsat = rl[15:0];
    end
    if (rr > SAT_HI) begin
      rsat = 16'h7fff;
    end else if (rr < SAT_LO) begin
      rsat = 16'h8000;
    end else begin
      rsat = rr[15:0];
    end
    case (md3_q)
      gtp_pkg::MODE_DRIVE: begin
        lp_d = lsat;
        rp_d = rsat;
      end
      gtp_pkg::MODE_LOST: begin
        lp_d = -gtp_pkg::SPIN_POWER;
        rp_d = gtp_pkg::SPIN_POWER;
      end
      default: begin
        lp_d = '0;
        rp_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lp_q  <= lp_d;
      rp_q  <= rp_d;
      md4_q <= md3_q;
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS+3:0], in_valid_i};
    end
  end

  assign out_valid_o   = v_q[NS+4];
  assign left_power_o  = lp_q;
  assign right_power_o = rp_q;
  assign mode_o        = md4_q;
  assign arrived_o     = (md4_q == gtp_pkg::MODE_ARRIVED);

endmodule
